// ===== rtl/utf8v_pkg.sv =====
// Shared types, codes and constants for the UTF-8 text validator.
package utf8v_pkg;

  localparam int unsigned CountW = 21;
  localparam int unsigned ByteW = 8;
  localparam int unsigned VerdictW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [CountW-1:0] MaxBytesReset = 21'd262144;

  localparam logic [VerdictW-1:0] V_OK = 3'd0;
  localparam logic [VerdictW-1:0] V_VALID = 3'd1;
  localparam logic [VerdictW-1:0] V_TOO_LARGE = 3'd2;
  localparam logic [VerdictW-1:0] V_INVALID = 3'd3;
  localparam logic [VerdictW-1:0] V_TRUNCATED = 3'd4;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_SIZE = 2'd1;
  localparam logic [1:0] ERR_ENC = 2'd2;

  localparam logic [ByteW-1:0] ContLow = 8'h80;
  localparam logic [ByteW-1:0] ContHigh = 8'hbf;

  localparam logic [ApbAddrW-1:0] REG_MAX_BYTES = 3'd0;

  typedef struct packed {
    logic [1:0]        pend;
    logic [ByteW-1:0]  low_bound;
    logic [ByteW-1:0]  high_bound;
    logic [CountW-1:0] count;
    logic [1:0]        err;
  } dec_state_t;

  localparam dec_state_t StateReset = '{
    pend: 2'd0,
    low_bound: ContLow,
    high_bound: ContHigh,
    count: '0,
    err: ERR_NONE
  };

endpackage

// ===== rtl/utf8_text_validator.sv =====
// Top level of the strict UTF-8 text validator: state, result register and register block.
// The verdict for a byte is registered and appears in the cycle after its beat is taken.
// Throughput: a byte per cycle if not stalled; the decode state register closes the only loop.
// A beat is taken whenever the result register is empty or its beat is taken in the same cycle.
// Reset (synchronous, active low) clears the decode state and the result valid flag and
// sets the size limit to 262144 bytes.
module utf8_text_validator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [utf8v_pkg::ByteW-1:0]         in_data_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [utf8v_pkg::VerdictW-1:0]      out_verdict,
  output logic                                out_final_flag,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [utf8v_pkg::ApbAddrW-1:0]      paddr,
  input  logic [utf8v_pkg::ApbDataW-1:0]      pwdata,
  output logic [utf8v_pkg::ApbDataW-1:0]      prdata,
  output logic                                pready
);

  utf8v_pkg::dec_state_t              st_r;
  utf8v_pkg::dec_state_t              st_nxt;
  logic [utf8v_pkg::CountW-1:0]       max_bytes;
  logic [utf8v_pkg::VerdictW-1:0]     verdict_nxt;
  logic [utf8v_pkg::VerdictW-1:0]     verdict_r;
  logic                               final_r;
  logic                               out_valid_r;
  logic                               in_acc;

  utf8v_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_bytes (max_bytes)
  );

  utf8v_step u_step (
    .st        (st_r),
    .max_bytes (max_bytes),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .st_nxt    (st_nxt),
    .verdict   (verdict_nxt)
  );

  assign in_stall = out_valid_r && out_stall;
  assign in_acc = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_verdict = verdict_r;
  assign out_final_flag = final_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= utf8v_pkg::StateReset;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      verdict_r <= verdict_nxt;
      final_r <= in_last_byte;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte) |=> (st_r.count == '0 && st_r.pend == 2'd0
                                  && st_r.err == utf8v_pkg::ERR_NONE))
    else $error("State not cleared after the final beat of a payload.");

  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_valid && out_final_flag == $past(in_last_byte)))
    else $error("Accepted beat did not produce a result.");

  a_end_verdicts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_verdict == utf8v_pkg::V_VALID
                   || out_verdict == utf8v_pkg::V_TRUNCATED)) |-> out_final_flag)
    else $error("Completion verdict on a beat that does not end the payload.");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && st_r.err == utf8v_pkg::ERR_NONE && st_r.count >= max_bytes)
      |-> (verdict_nxt == utf8v_pkg::V_TOO_LARGE))
    else $error("Byte beyond the size limit not reported as too large.");

endmodule

// ===== rtl/utf8v_cfg.sv =====
// APB-style register block holding the payload size limit.
module utf8v_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [utf8v_pkg::ApbAddrW-1:0]      paddr,
  input  logic [utf8v_pkg::ApbDataW-1:0]      pwdata,
  output logic [utf8v_pkg::ApbDataW-1:0]      prdata,
  output logic                                pready,
  output logic [utf8v_pkg::CountW-1:0]        max_bytes
);

  logic [utf8v_pkg::CountW-1:0] max_bytes_r;
  logic                         wr_en;
  logic                         sel_max;

  assign sel_max = (paddr[utf8v_pkg::ApbAddrW-1]
                    == utf8v_pkg::REG_MAX_BYTES[utf8v_pkg::ApbAddrW-1]);
  assign wr_en = psel && penable && pwrite && sel_max;
  assign pready = 1'b1;
  assign max_bytes = max_bytes_r;

  always_comb begin
    prdata = '0;
    if (sel_max) begin
      prdata = {{(utf8v_pkg::ApbDataW - utf8v_pkg::CountW){1'b0}}, max_bytes_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= utf8v_pkg::MaxBytesReset;
    end else if (wr_en) begin
      max_bytes_r <= pwdata[utf8v_pkg::CountW-1:0];
    end
  end

endmodule

// ===== rtl/utf8v_step.sv =====
// Next-state and verdict logic for one payload byte.
module utf8v_step (
  input  utf8v_pkg::dec_state_t               st,
  input  logic [utf8v_pkg::CountW-1:0]        max_bytes,
  input  logic [utf8v_pkg::ByteW-1:0]         data_byte,
  input  logic                                last_byte,
  output utf8v_pkg::dec_state_t               st_nxt,
  output logic [utf8v_pkg::VerdictW-1:0]      verdict
);

  utf8v_pkg::dec_state_t dec;
  logic                  byte_ok;

  // Decoding of the byte against the pending sequence; the size limit and any earlier error are not yet applied.
  always_comb begin
    dec = st;
    byte_ok = 1'b0;
    dec.count = st.count + 1'b1;
    if (st.pend != 2'd0) begin
      byte_ok = (data_byte >= st.low_bound) && (data_byte <= st.high_bound);
      if (byte_ok) begin
        dec.pend = st.pend - 1'b1;
        dec.low_bound = utf8v_pkg::ContLow;
        dec.high_bound = utf8v_pkg::ContHigh;
      end
    end else if (data_byte < 8'h80) begin
      byte_ok = !(((data_byte < 8'h20) && (data_byte != 8'h09) && (data_byte != 8'h0a))
                  || (data_byte == 8'h7f));
    end else if ((data_byte >= 8'hc2) && (data_byte <= 8'hdf)) begin
      byte_ok = 1'b1;
      dec.pend = 2'd1;
      dec.low_bound = utf8v_pkg::ContLow;
      dec.high_bound = utf8v_pkg::ContHigh;
    end else if ((data_byte >= 8'he0) && (data_byte <= 8'hef)) begin
      byte_ok = 1'b1;
      dec.pend = 2'd2;
      dec.low_bound = (data_byte == 8'he0) ? 8'ha0 : utf8v_pkg::ContLow;
      dec.high_bound = (data_byte == 8'hed) ? 8'h9f : utf8v_pkg::ContHigh;
    end else if ((data_byte >= 8'hf0) && (data_byte <= 8'hf4)) begin
      byte_ok = 1'b1;
      dec.pend = 2'd3;
      dec.low_bound = (data_byte == 8'hf0) ? 8'h90 : utf8v_pkg::ContLow;
      dec.high_bound = (data_byte == 8'hf4) ? 8'h8f : utf8v_pkg::ContHigh;
    end
    if (!byte_ok) begin
      dec.err = utf8v_pkg::ERR_ENC;
    end
  end

  always_comb begin
    utf8v_pkg::dec_state_t upd;
    upd = st;
    if (st.err == utf8v_pkg::ERR_NONE) begin
      if (st.count >= max_bytes) begin
        upd.err = utf8v_pkg::ERR_SIZE;
      end else begin
        upd = dec;
      end
    end

    priority if (upd.err == utf8v_pkg::ERR_SIZE) begin
      verdict = utf8v_pkg::V_TOO_LARGE;
    end else if (upd.err != utf8v_pkg::ERR_NONE) begin
      verdict = utf8v_pkg::V_INVALID;
    end else if (last_byte) begin
      verdict = (upd.pend != 2'd0) ? utf8v_pkg::V_TRUNCATED : utf8v_pkg::V_VALID;
    end else begin
      verdict = utf8v_pkg::V_OK;
    end

    st_nxt = last_byte ? utf8v_pkg::StateReset : upd;
  end

endmodule

// ===== tb/sv/tb_utf8_text_validator.sv =====
// Self-checking testbench for the strict UTF-8 text validator, with a byte-level predictor.
`timescale 1ns / 100ps

module tb_utf8_text_validator;

  localparam int QuietLimit = 1000;
  localparam int LongHold = 80;
  localparam int PhaseBytes = 110;

  typedef struct packed {
    logic [utf8v_pkg::ByteW-1:0] data;
    logic                        last;
  } beat_t;

  typedef struct packed {
    logic [utf8v_pkg::VerdictW-1:0] verdict;
    logic                           final_flag;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [utf8v_pkg::ByteW-1:0]    in_data_byte = '0;
  logic                           in_last_byte = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [utf8v_pkg::VerdictW-1:0] out_verdict;
  logic                           out_final_flag;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [utf8v_pkg::ApbAddrW-1:0] paddr = '0;
  logic [utf8v_pkg::ApbDataW-1:0] pwdata = '0;
  logic [utf8v_pkg::ApbDataW-1:0] prdata;
  logic                           pready;

  beat_t                        beats_q[$];
  verdict_t                     verdict_q[$];
  verdict_t                     want;
  verdict_t                     want_in;
  utf8v_pkg::dec_state_t        text_st = utf8v_pkg::StateReset;
  logic [utf8v_pkg::CountW-1:0] limit_bytes = utf8v_pkg::MaxBytesReset;

  int  mismatches = 0;
  int  quiet = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  bit  calm = 1'b0;

  utf8_text_validator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_verdict(out_verdict),
    .out_final_flag(out_final_flag),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input int exp_val, input int act_val);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %0h, got %0h", what, exp_val, act_val);
    end
  endtask

  function automatic logic [utf8v_pkg::VerdictW-1:0] judge_byte(
      input logic [utf8v_pkg::ByteW-1:0] c, input logic last);
    logic ok;
    logic [utf8v_pkg::VerdictW-1:0] v;
    ok = 1'b1;
    if (text_st.err == utf8v_pkg::ERR_NONE) begin
      if (text_st.count >= limit_bytes) begin
        text_st.err = utf8v_pkg::ERR_SIZE;
      end else begin
        text_st.count = text_st.count + 1'b1;
        if (text_st.pend != 2'd0) begin
          if (c < text_st.low_bound || c > text_st.high_bound) begin
            ok = 1'b0;
          end else begin
            text_st.pend = text_st.pend - 2'd1;
            text_st.low_bound = utf8v_pkg::ContLow;
            text_st.high_bound = utf8v_pkg::ContHigh;
          end
        end else if (c < 8'h80) begin
          ok = !((c < 8'h20 && c != 8'h09 && c != 8'h0a) || c == 8'h7f);
        end else if (c >= 8'hc2 && c <= 8'hdf) begin
          text_st.pend = 2'd1;
          text_st.low_bound = utf8v_pkg::ContLow;
          text_st.high_bound = utf8v_pkg::ContHigh;
        end else if (c >= 8'he0 && c <= 8'hef) begin
          text_st.pend = 2'd2;
          text_st.low_bound = (c == 8'he0) ? 8'ha0 : utf8v_pkg::ContLow;
          text_st.high_bound = (c == 8'hed) ? 8'h9f : utf8v_pkg::ContHigh;
        end else if (c >= 8'hf0 && c <= 8'hf4) begin
          text_st.pend = 2'd3;
          text_st.low_bound = (c == 8'hf0) ? 8'h90 : utf8v_pkg::ContLow;
          text_st.high_bound = (c == 8'hf4) ? 8'h8f : utf8v_pkg::ContHigh;
        end else begin
          ok = 1'b0;
        end
        if (!ok) text_st.err = utf8v_pkg::ERR_ENC;
      end
    end
    if (text_st.err == utf8v_pkg::ERR_SIZE) v = utf8v_pkg::V_TOO_LARGE;
    else if (text_st.err != utf8v_pkg::ERR_NONE) v = utf8v_pkg::V_INVALID;
    else if (last) v = (text_st.pend != 2'd0) ? utf8v_pkg::V_TRUNCATED : utf8v_pkg::V_VALID;
    else v = utf8v_pkg::V_OK;
    if (last) text_st = utf8v_pkg::StateReset;
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        want_in.verdict = judge_byte(in_data_byte, in_last_byte);
        want_in.final_flag = in_last_byte;
        verdict_q.push_back(want_in);
        beats_q.pop_front();
      end
      if (in_valid && in_stall) begin
        // A stalled beat is held as it is.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (beats_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else if (beats_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data_byte <= beats_q[0].data;
        in_last_byte <= beats_q[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch("result with nothing pending", 0, int'(out_verdict));
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want.verdict) begin
            flag_mismatch("verdict", int'(want.verdict), int'(out_verdict));
          end
          if (out_final_flag !== want.final_flag) begin
            flag_mismatch("final_flag", int'(want.final_flag), int'(out_final_flag));
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic put(input logic [utf8v_pkg::ByteW-1:0] b, input logic l);
    beats_q.push_back('{data: b, last: l});
  endtask

  function automatic logic [20:0] pick_cp(input int lo, input int hi);
    case ($urandom_range(0, 7))
      0: return 21'(lo);
      1: return 21'(hi);
      default: return 21'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic rand_payload(input int n_chars);
    logic [utf8v_pkg::ByteW-1:0] pl[$];
    logic [20:0] cp;
    int kind;
    int k;
    for (k = 0; k < n_chars; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        case ($urandom_range(0, 5))
          0: cp = 21'h09;
          1: cp = 21'h0a;
          default: cp = pick_cp(32'h20, 32'h7e);
        endcase
        pl.push_back(cp[7:0]);
      end else if (kind < 45) begin
        cp = pick_cp(32'h80, 32'h7ff);
        pl.push_back({3'b110, cp[10:6]});
        pl.push_back({2'b10, cp[5:0]});
      end else if (kind < 65) begin
        cp = pick_cp(32'h800, 32'hffff);
        if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp - 21'h800;
        pl.push_back({4'b1110, cp[15:12]});
        pl.push_back({2'b10, cp[11:6]});
        pl.push_back({2'b10, cp[5:0]});
      end else if (kind < 80) begin
        cp = pick_cp(32'h10000, 32'h10ffff);
        pl.push_back({5'b11110, cp[20:18]});
        pl.push_back({2'b10, cp[17:12]});
        pl.push_back({2'b10, cp[11:6]});
        pl.push_back({2'b10, cp[5:0]});
      end else if (kind < 90) begin
        pl.push_back(utf8v_pkg::ByteW'($urandom_range(0, 255)));
      end else if (kind < 95) begin
        pl.push_back(utf8v_pkg::ByteW'($urandom_range(192, 255)));
        pl.push_back(utf8v_pkg::ByteW'($urandom_range(128, 191)));
      end else begin
        pl.push_back($urandom_range(0, 1) ? 8'hed : 8'hf4);
        pl.push_back(utf8v_pkg::ByteW'($urandom_range(128, 191)));
        pl.push_back(utf8v_pkg::ByteW'($urandom_range(128, 191)));
      end
    end
    if (pl.size() > 1 && $urandom_range(0, 9) == 0) pl.pop_back();
    for (k = 0; k < pl.size(); k++) put(pl[k], k == pl.size() - 1);
  endtask

  task automatic write_limit(input logic [utf8v_pkg::CountW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= utf8v_pkg::REG_MAX_BYTES;
    pwdata <= utf8v_pkg::ApbDataW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_bytes = val;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[utf8v_pkg::CountW-1:0] !== val) begin
      flag_mismatch("limit readback", int'(val), int'(prdata));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    while (beats_q.size() != 0 || verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    logic [utf8v_pkg::CountW-1:0] phase_limit [7];
    int p;
    int added;
    int n0;
    phase_limit[0] = 21'd1;
    phase_limit[1] = 21'd2;
    phase_limit[2] = 21'd3;
    phase_limit[3] = utf8v_pkg::CountW'($urandom_range(30, 4));
    phase_limit[4] = 21'd1048576;
    phase_limit[5] = utf8v_pkg::CountW'($urandom_range(12, 6));
    phase_limit[6] = utf8v_pkg::MaxBytesReset;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Control characters, DEL, overlong forms, surrogates, beyond U+10FFFF, truncation.
    put(8'h00, 1);
    put(8'h09, 0); put(8'h0a, 0); put(8'h7e, 0); put(8'h20, 1);
    put(8'h7f, 1);
    put(8'hc2, 0); put(8'h80, 0); put(8'hdf, 0); put(8'hbf, 1);
    put(8'hc1, 1);
    put(8'he0, 0); put(8'h9f, 1);
    put(8'hed, 0); put(8'ha0, 1);
    put(8'hf0, 0); put(8'h90, 0); put(8'h80, 0); put(8'h80, 1);
    put(8'hf4, 0); put(8'h90, 1);
    put(8'hff, 0); put(8'h41, 1);
    put(8'he1, 0); put(8'h80, 1);
    settle();

    for (p = 0; p < 7; p++) begin
      write_limit(phase_limit[p]);
      if (p == 4) hold_req = 1'b1;
      if (p == 6) calm = 1'b1;
      added = 0;
      while (added < PhaseBytes) begin
        n0 = beats_q.size();
        rand_payload(($urandom_range(0, 9) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1));
        added += beats_q.size() - n0;
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
